// ===== design/glcd_pkg.sv =====
package glcd_pkg;

  // display geometry
  localparam int PAGE_COUNT   = 8;
  localparam int COLUMN_COUNT = 64;
  localparam int CHIP_COUNT   = 2;
  localparam int RAM_DEPTH    = PAGE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W       = $clog2(RAM_DEPTH);

  // instruction decode masks and codes
  localparam logic [7:0] INS_DISPLAY_MASK = 8'hfe;
  localparam logic [7:0] INS_DISPLAY      = 8'h3e;
  localparam logic [7:0] INS_PAGE_MASK    = 8'hf8;
  localparam logic [7:0] INS_PAGE         = 8'hb8;
  localparam logic [7:0] INS_COLUMN_MASK  = 8'hc0;
  localparam logic [7:0] INS_COLUMN       = 8'h40;
  localparam logic [5:0] COLUMN_FIELD     = 6'h3f;

  // status byte
  localparam logic [7:0] STATUS_OFF  = 8'h20;
  localparam logic [7:0] STATUS_BUSY = 8'h80;

  // access kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam logic SEL_INSTR = 1'b0;
  localparam logic SEL_DATA  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [1:0] chip_select;
    logic       data_select;
    logic [7:0] write_data;
  } glcd_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       was_read;
  } glcd_out_t;

endpackage

// ===== design/dual_chip_glcd_controller_unit.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data (glcd_in_t)
// out     | output    | out_valid / out_ready | out_data (glcd_out_t)
//
// one item per cycle while results are taken; its result appears in the output register the next cycle
// each chip's display ram is one single-port ram; a data read reloads the latch
// from its registered read port, which holds the byte until the next data read
// synchronous reset clears pointers, display flags, latches and output valid,
// and holds in_ready low
// while a result waits unaccepted, in_ready is low and no state changes
module dual_chip_glcd_controller_unit import glcd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  glcd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output glcd_out_t out_data
);

  logic      accept;
  glcd_out_t out_next;

  logic [7:0] latch_val [CHIP_COUNT];
  logic [7:0] status    [CHIP_COUNT];

  // input side stalls only behind an unaccepted result, and during reset
  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  for (genvar c = 0; c < CHIP_COUNT; c++) begin : g_chip
    logic [2:0]        page_ptr, page_ptr_next;
    logic [5:0]        col_ptr, col_ptr_next;
    logic              panel_on, panel_on_next;
    logic              latch_src, latch_src_next;
    logic              sel;
    logic              addr_ok;
    logic [6:0]        col_inc;
    logic [5:0]        col_adv;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;

    assign sel     = accept && in_data.chip_select[c];
    assign addr_ok = ({1'b0, page_ptr} < 4'(PAGE_COUNT)) &&
                     ({1'b0, col_ptr} < 7'(COLUMN_COUNT));
    assign ram_addr = ADDR_W'(int'(page_ptr) * COLUMN_COUNT + int'(col_ptr));

    // column advance with wrap
    assign col_inc = {1'b0, col_ptr} + 7'd1;
    assign col_adv = (col_inc >= 7'(COLUMN_COUNT) || col_inc > 7'h3f) ? 6'd0
                                                                     : col_inc[5:0];

    // ram strobes
    assign ram_we = sel && in_data.req_type == REQ_WRITE &&
                    in_data.data_select == SEL_DATA && addr_ok;
    assign ram_re = sel && in_data.req_type == REQ_READ &&
                    in_data.data_select == SEL_DATA && addr_ok;

    // latch is the ram read register when loaded from ram, else zero
    assign latch_val[c] = latch_src ? ram_rdata : 8'd0;
    assign status[c]    = (panel_on ? 8'd0 : STATUS_OFF) & ~STATUS_BUSY;

    // pointer and flag updates
    always_comb begin
      page_ptr_next  = page_ptr;
      col_ptr_next   = col_ptr;
      panel_on_next  = panel_on;
      latch_src_next = latch_src;
      if (sel) begin
        if (in_data.data_select == SEL_DATA) begin
          col_ptr_next = col_adv;
          if (in_data.req_type == REQ_READ) begin
            latch_src_next = addr_ok;
          end
        end else if (in_data.req_type == REQ_WRITE) begin
          if ((in_data.write_data & INS_DISPLAY_MASK) == INS_DISPLAY) begin
            panel_on_next = in_data.write_data[0];
          end else if ((in_data.write_data & INS_PAGE_MASK) == INS_PAGE) begin
            page_ptr_next = in_data.write_data[2:0];
          end else if ((in_data.write_data & INS_COLUMN_MASK) == INS_COLUMN) begin
            col_ptr_next = in_data.write_data[5:0] & COLUMN_FIELD;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        page_ptr  <= '0;
        col_ptr   <= '0;
        panel_on  <= 1'b0;
        latch_src <= 1'b0;
      end else begin
        page_ptr  <= page_ptr_next;
        col_ptr   <= col_ptr_next;
        panel_on  <= panel_on_next;
        latch_src <= latch_src_next;
      end
    end

    glcd_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we),
      .re   (ram_re),
      .addr (ram_addr),
      .wdata(in_data.write_data),
      .rdata(ram_rdata)
    );
  end

  // answer from the lowest selected chip
  always_comb begin
    logic [7:0] answer;
    answer = 8'd0;
    for (int c = CHIP_COUNT - 1; c >= 0; c--) begin
      if (in_data.chip_select[c]) begin
        answer = (in_data.data_select == SEL_DATA) ? latch_val[c] : status[c];
      end
    end
    out_next.was_read  = in_data.req_type;
    out_next.read_data = (in_data.req_type == REQ_READ) ? answer : 8'd0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_next;
    end
  end

  // checks
  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.req_type == REQ_WRITE) |=>
      (out_valid && !out_data.was_read && out_data.read_data == 8'd0))
    else $error("write item did not give a zero answer");

  a_status_bits: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.req_type == REQ_READ && in_data.data_select == SEL_INSTR) |=>
      (out_data.was_read && (out_data.read_data & ~STATUS_OFF) == 8'd0))
    else $error("status read carried bits other than the off bit");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted while a result was stalled");

endmodule

// ===== design/glcd_ram.sv =====
module glcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read that holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
